// File: hdl/rns_pkg.sv
package rns_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int COORD_BITS    = 16;
    localparam int IDX_W         = $clog2(MAX_POINTS);
    localparam int POINT_W       = 2 * COORD_BITS;
    localparam int RADIUS_W      = 2 * COORD_BITS + 1;
    localparam int COUNT_W       = IDX_W + 1;
    localparam int CAP_NEIGHBORS = 64;
    localparam int NB_W          = 7;
    localparam int CFG_IDX_W     = 2;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_SQ   = 2'd0,
        CFG_SELF_LOOPS  = 2'd1,
        CFG_NB_LIMIT    = 2'd2,
        CFG_POINT_COUNT = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND_RD,
        ST_SEND_LD,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                          kind;
        logic [IDX_W-1:0]              point_index;
        logic signed [COORD_BITS-1:0]  coord_x;
        logic signed [COORD_BITS-1:0]  coord_y;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] sender_index;
        logic [IDX_W-1:0] receiver_index;
        logic             found;
        logic             last;
    } rsp_t;

    // search settings handed to the sequencer
    typedef struct packed {
        logic               self_loops;
        logic [NB_W-1:0]    nb_limit;
        logic [COUNT_W-1:0] point_count;
    } search_cfg_t;

    // sequencer controls for the distance unit
    typedef struct packed {
        logic adv;
        logic sender_ld;
    } dist_ctl_t;

endpackage

// File: hdl/rns_ram.sv
module rns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/rns_dist.sv
module rns_dist (
    input  logic                              clk,
    input  rns_pkg::dist_ctl_t                ctl,
    input  logic [rns_pkg::POINT_W-1:0]       point,
    input  logic [rns_pkg::RADIUS_W-1:0]      radius_sq,
    output logic                              hit
);

    localparam int CB     = rns_pkg::COORD_BITS;
    localparam int DIFF_W = CB + 1;
    localparam int SQ_W   = 2 * CB;
    localparam int SUM_W  = SQ_W + 1;

    logic [CB-1:0]   sender_x_reg;
    logic [CB-1:0]   sender_y_reg;
    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        dx_abs;
    logic [DIFF_W-1:0]        dy_abs;
    logic [CB-1:0]            ax;
    logic [CB-1:0]            ay;
    logic [SQ_W-1:0]          sqx_next;
    logic [SQ_W-1:0]          sqy_next;

    always_comb
    begin
        dx = DIFF_W'($signed(point[CB-1:0])) - DIFF_W'($signed(sender_x_reg));
        dy = DIFF_W'($signed(point[2*CB-1:CB])) - DIFF_W'($signed(sender_y_reg));
        dx_abs = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        dy_abs = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        // magnitude of a difference never exceeds the coordinate range
        ax = dx_abs[CB-1:0];
        ay = dy_abs[CB-1:0];
        sqx_next = SQ_W'(ax) * SQ_W'(ax);
        sqy_next = SQ_W'(ay) * SQ_W'(ay);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sender_ld)
        begin
            sender_x_reg <= point[CB-1:0];
            sender_y_reg <= point[2*CB-1:CB];
        end
        if (ctl.adv)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
    end

    assign hit = (SUM_W'(sqx_reg) + SUM_W'(sqy_reg)) < radius_sq;

endmodule

// File: hdl/rns_ctrl.sv
module rns_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rns_pkg::search_cfg_t             cfg,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  rns_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rns_pkg::rsp_t                    rsp,
    output logic                             rd_en,
    output logic [rns_pkg::IDX_W-1:0]        rd_addr,
    output rns_pkg::dist_ctl_t               dist_ctl,
    input  logic                             dist_hit
);

    localparam int IW = rns_pkg::IDX_W;
    localparam int CW = rns_pkg::COUNT_W;
    localparam int NW = rns_pkg::NB_W;

    rns_pkg::state_t state_reg, state_next;

    logic [IW-1:0]  q_idx_reg, q_idx_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [NW-1:0]  n_reg, n_next;
    logic           s1_valid_reg, s1_valid_next;
    logic [IW-1:0]  s1_idx_reg, s1_idx_next;
    logic           s2_valid_reg, s2_valid_next;
    logic [IW-1:0]  s2_idx_reg, s2_idx_next;
    logic           held_valid_reg, held_valid_next;
    logic [IW-1:0]  held_idx_reg, held_idx_next;
    logic           rsp_valid_reg, rsp_valid_next;
    rns_pkg::rsp_t  rsp_reg, rsp_next;

    logic [NW-1:0]  cap_eff;
    logic [CW-1:0]  count_eff;
    logic           query_acc;
    logic           issuing;
    logic           s2_hit;
    logic           out_free;
    logic           stall;
    logic           adv;
    logic           capped;
    logic           walk_end;
    logic           push_walk;
    logic           push_fin;

    always_comb
    begin
        cap_eff = (cfg.nb_limit == '0 || cfg.nb_limit > NW'(rns_pkg::CAP_NEIGHBORS))
                ? NW'(rns_pkg::CAP_NEIGHBORS) : cfg.nb_limit;
        count_eff = (cfg.point_count > CW'(rns_pkg::MAX_POINTS))
                  ? CW'(rns_pkg::MAX_POINTS) : cfg.point_count;
        query_acc = req_valid && req_ready && (req.kind == rns_pkg::KIND_QUERY);
        issuing   = (state_reg == rns_pkg::ST_WALK) && (j_reg < count_eff);
        s2_hit    = s2_valid_reg && dist_hit
                  && !((s2_idx_reg == q_idx_reg) && !cfg.self_loops);
        out_free  = !rsp_valid_reg || rsp_ready;
        // a second hit needs the output register to move the held one out
        stall     = (state_reg == rns_pkg::ST_WALK) && s2_hit && held_valid_reg && !out_free;
        adv       = (state_reg == rns_pkg::ST_WALK) && !stall;
        capped    = adv && s2_hit && ((n_reg + NW'(1)) == cap_eff);
        walk_end  = (state_reg == rns_pkg::ST_WALK) && !issuing
                  && !s1_valid_reg && !s2_valid_reg;
        push_walk = adv && s2_hit && held_valid_reg;
        push_fin  = (state_reg == rns_pkg::ST_FINISH) && out_free;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rns_pkg::ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next = rns_pkg::ST_SEND_RD;
                end
            end
            rns_pkg::ST_SEND_RD:
            begin
                state_next = rns_pkg::ST_SEND_LD;
            end
            rns_pkg::ST_SEND_LD:
            begin
                state_next = rns_pkg::ST_WALK;
            end
            rns_pkg::ST_WALK:
            begin
                if (capped || walk_end)
                begin
                    state_next = rns_pkg::ST_FINISH;
                end
            end
            rns_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = rns_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready          = 1'b0;
        rd_en              = 1'b0;
        rd_addr            = j_reg[IW-1:0];
        dist_ctl.adv       = adv;
        dist_ctl.sender_ld = 1'b0;
        unique case (state_reg)
            rns_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            rns_pkg::ST_SEND_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = q_idx_reg;
            end
            rns_pkg::ST_SEND_LD:
            begin
                dist_ctl.sender_ld = 1'b1;
            end
            rns_pkg::ST_WALK:
            begin
                rd_en = issuing && adv;
            end
            rns_pkg::ST_FINISH:
            begin
            end
        endcase
    end

    // walk pipeline, held receiver and result register
    always_comb
    begin
        q_idx_next      = q_idx_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        s2_valid_next   = s2_valid_reg;
        s2_idx_next     = s2_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (query_acc)
        begin
            q_idx_next      = req.point_index;
            j_next          = '0;
            n_next          = '0;
            s1_valid_next   = 1'b0;
            s2_valid_next   = 1'b0;
            held_valid_next = 1'b0;
        end

        if (adv)
        begin
            j_next        = j_reg + CW'(issuing);
            s1_valid_next = issuing;
            s1_idx_next   = j_reg[IW-1:0];
            s2_valid_next = s1_valid_reg;
            s2_idx_next   = s1_idx_reg;
            if (s2_hit)
            begin
                held_valid_next = 1'b1;
                held_idx_next   = s2_idx_reg;
                n_next          = n_reg + NW'(1);
            end
            if (capped)
            begin
                s1_valid_next = 1'b0;
                s2_valid_next = 1'b0;
            end
        end

        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (push_walk)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.sender_index   = q_idx_reg;
            rsp_next.receiver_index = held_idx_reg;
            rsp_next.found          = 1'b1;
            rsp_next.last           = 1'b0;
        end
        else if (push_fin)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.sender_index   = q_idx_reg;
            rsp_next.receiver_index = held_valid_reg ? held_idx_reg : '0;
            rsp_next.found          = held_valid_reg;
            rsp_next.last           = 1'b1;
            held_valid_next         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rns_pkg::ST_IDLE;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            j_reg          <= '0;
            n_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            held_valid_reg <= held_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            j_reg          <= j_next;
            n_reg          <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_idx_reg    <= q_idx_next;
        s1_idx_reg   <= s1_idx_next;
        s2_idx_reg   <= s2_idx_next;
        held_idx_reg <= held_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hdl/radius_neighbor_search_core.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | rns_pkg::req_t (load or query)
// rsp     | out       | rsp_valid / rsp_ready | rns_pkg::rsp_t (one receiver)
// cfg     | in        | cfg_write             | cfg_index, cfg_data
//
// a load leaves req_ready high; a query keeps req_ready low until its walk over
// point_count stored points (capped at the store size) ends; the single distance unit
// visits one stored point per cycle unless stalled; a neighbor cap can end it early
// results leave through an output register; a stalled result can freeze the walk
// rst_n is asynchronous; the point store is not cleared and needs no sweep
module radius_neighbor_search_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  rns_pkg::req_t                     req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output rns_pkg::rsp_t                     rsp,
    input  logic                              cfg_write,
    input  logic [rns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rns_pkg::RADIUS_W-1:0]      cfg_data
);

    logic [rns_pkg::RADIUS_W-1:0] radius_sq_reg;
    logic                         self_loops_reg;
    logic [rns_pkg::NB_W-1:0]     nb_limit_reg;
    logic [rns_pkg::COUNT_W-1:0]  point_count_reg;

    rns_pkg::search_cfg_t         search_cfg;
    rns_pkg::dist_ctl_t           dist_ctl;
    logic                         dist_hit;
    logic                         wr_en;
    logic                         rd_en;
    logic [rns_pkg::IDX_W-1:0]    rd_addr;
    logic [rns_pkg::POINT_W-1:0]  rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg   <= '0;
            self_loops_reg  <= 1'b0;
            nb_limit_reg    <= rns_pkg::NB_W'(rns_pkg::CAP_NEIGHBORS);
            point_count_reg <= rns_pkg::COUNT_W'(rns_pkg::MAX_POINTS);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rns_pkg::CFG_RADIUS_SQ:   radius_sq_reg   <= cfg_data;
                rns_pkg::CFG_SELF_LOOPS:  self_loops_reg  <= cfg_data[0];
                rns_pkg::CFG_NB_LIMIT:    nb_limit_reg    <= cfg_data[rns_pkg::NB_W-1:0];
                rns_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data[rns_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        search_cfg.self_loops  = self_loops_reg;
        search_cfg.nb_limit    = nb_limit_reg;
        search_cfg.point_count = point_count_reg;
    end

    assign wr_en = req_valid && req_ready && (req.kind == rns_pkg::KIND_LOAD);

    rns_ram #(
        .WIDTH (rns_pkg::POINT_W),
        .DEPTH (rns_pkg::MAX_POINTS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (req.point_index),
        .wr_data ({req.coord_y, req.coord_x}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rns_dist u_dist (
        .clk       (clk),
        .ctl       (dist_ctl),
        .point     (rd_data),
        .radius_sq (radius_sq_reg),
        .hit       (dist_hit)
    );

    rns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (search_cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .dist_ctl  (dist_ctl),
        .dist_hit  (dist_hit)
    );

endmodule

// File: hdl/rns_checker.sv
module rns_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input rns_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input rns_pkg::rsp_t rsp
);

    // a pending result transaction holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // a not-found result closes its query
    a_notfound_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.last)
        else $error("not-found result without last");

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.receiver_index == '0)
        else $error("not-found result with nonzero receiver");

    // a query transaction occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.kind == rns_pkg::KIND_QUERY |=> !req_ready)
        else $error("ready right after a query");

    // a load leaves the block ready
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.kind == rns_pkg::KIND_LOAD |=> req_ready)
        else $error("ready dropped after a load");

endmodule

bind radius_neighbor_search_core rns_checker u_rns_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
